FILE: rtl/bdpc_pkg.sv
package bdpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned LevelW = 2;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned RegIdxW = 8;

  // Configuration register indexes.
  localparam logic [RegIdxW-1:0] REG_DEBOUNCE   = 8'd0;
  localparam logic [RegIdxW-1:0] REG_LONG_PRESS = 8'd1;

  localparam logic [CfgW-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CfgW-1:0] LONG_PRESS_RESET = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic [LevelW-1:0] pressed_levels;
    logic              restart;
    logic              take_request;
    logic [IdxW-1:0]   button_index;
    logic              discard_all;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        taken_event;
    logic [LevelW-1:0] raw_levels;
    logic [LevelW-1:0] stable_levels;
    logic [TimeW-1:0]  held_ms;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic restart;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic             raw;
    logic             stable;
    event_e           pending;
    logic [TimeW-1:0] held;
  } lane_stat_t;

endpackage

FILE: rtl/bdpc_in_if.sv
interface bdpc_in_if
  import bdpc_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/bdpc_out_if.sv
interface bdpc_out_if
  import bdpc_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/bdpc_cfg_if.sv
interface bdpc_cfg_if
  import bdpc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bdpc_lane.sv
module bdpc_lane
  import bdpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             lvl_i,
  input  logic [TimeW-1:0] now_i,
  input  lane_ctrl_t       ctrl_i,
  input  cfg_t             cfg_i,
  output lane_stat_t       stat_o
);

  logic             raw_q, raw_d;
  logic             stable_q, stable_d;
  logic             armed_q, armed_d;
  logic             long_done_q, long_done_d;
  logic [TimeW-1:0] rct_q, rct_d;
  logic [TimeW-1:0] pst_q, pst_d;
  event_e           pend_q, pend_d;

  logic             raw_chg, settle, press, release_s, long_hit;
  logic [TimeW-1:0] raw_diff, press_diff, held;
  event_e           ev_upd;

  always_comb begin
    raw_chg    = lvl_i != raw_q;
    raw_diff   = raw_chg ? '0 : now_i - rct_q;
    settle     = (lvl_i != stable_q) && (raw_diff >= TimeW'(cfg_i.debounce_ms));
    press      = settle && lvl_i;
    release_s  = settle && !lvl_i;
    press_diff = press ? '0 : now_i - pst_q;

    raw_d       = lvl_i;
    rct_d       = raw_chg ? now_i : rct_q;
    stable_d    = settle ? lvl_i : stable_q;
    pst_d       = press ? now_i : pst_q;
    armed_d     = release_s ? 1'b1 : armed_q;
    long_done_d = press ? 1'b0 : long_done_q;

    ev_upd = pend_q;
    if (release_s && armed_q && !long_done_q && pend_q == EV_NONE) begin
      ev_upd = EV_SHORT;
    end
    long_hit = stable_d && armed_d && !long_done_d &&
               (press_diff >= TimeW'(cfg_i.long_press_ms));
    if (long_hit) begin
      long_done_d = 1'b1;
      if (ev_upd == EV_NONE) begin
        ev_upd = EV_LONG;
      end
    end
    held = stable_d ? press_diff : '0;

    if (ctrl_i.restart) begin
      raw_d       = lvl_i;
      stable_d    = lvl_i;
      armed_d     = !lvl_i;
      long_done_d = 1'b0;
      rct_d       = now_i;
      pst_d       = now_i;
      ev_upd      = EV_NONE;
      held        = '0;
    end

    // The take and the discard act after the update, so the lane reports
    // the event before they clear it.
    pend_d = ctrl_i.clear ? EV_NONE : ev_upd;

    stat_o.raw     = raw_d;
    stat_o.stable  = stable_d;
    stat_o.pending = ev_upd;
    stat_o.held    = held;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q       <= 1'b0;
      stable_q    <= 1'b0;
      armed_q     <= 1'b1;
      long_done_q <= 1'b0;
      rct_q       <= '0;
      pst_q       <= '0;
      pend_q      <= EV_NONE;
    end else if (en_i) begin
      raw_q       <= raw_d;
      stable_q    <= stable_d;
      armed_q     <= armed_d;
      long_done_q <= long_done_d;
      rct_q       <= rct_d;
      pst_q       <= pst_d;
      pend_q      <= pend_d;
    end
  end

endmodule

FILE: rtl/bdpc_merge.sv
module bdpc_merge
  import bdpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 2
) (
  input  lane_stat_t             stat_i [NUM_BUTTONS],
  input  logic                   take_i,
  input  logic [IdxW-1:0]        idx_i,
  output logic [NUM_BUTTONS-1:0] take_hit_o,
  output out_item_t              item_o
);

  logic [NUM_BUTTONS-1:0] raw_all;
  logic [NUM_BUTTONS-1:0] stable_all;
  event_e                 ev;
  logic [TimeW-1:0]       held;

  always_comb begin
    ev   = EV_NONE;
    held = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      raw_all[b]    = stat_i[b].raw;
      stable_all[b] = stat_i[b].stable;
      take_hit_o[b] = 1'b0;
      // An index past the last button matches no lane.
      if (int'(idx_i) == b) begin
        take_hit_o[b] = take_i;
        held          = stat_i[b].held;
        if (take_i) begin
          ev = stat_i[b].pending;
        end
      end
    end
    item_o.taken_event   = ev;
    item_o.raw_levels    = LevelW'(raw_all);
    item_o.stable_levels = LevelW'(stable_all);
    item_o.held_ms       = held;
  end

endmodule

FILE: rtl/button_debounce_press_classifier_core.sv
// Debounces NUM_BUTTONS push buttons and classifies each press as short or
// long. Every accepted sample updates all buttons at once, one lane per
// button, and yields exactly one result the next cycle; a new sample is taken
// every cycle unless output stalls, including the cycle in which the previous
// result transfers. This rate of one item per clock is set by the single output
// register holding the merged result. Only the two lowest buttons see sampled
// levels and appear in the level vectors; higher buttons read as released.
module button_debounce_press_classifier_core
  import bdpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdpc_in_if.sink     in_i,
  bdpc_out_if.source  out_o,
  bdpc_cfg_if.sink    cfg_i
);

  cfg_t      cfg_q, cfg_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  logic                   in_fire;
  logic [NUM_BUTTONS-1:0] take_hit;
  lane_stat_t             stat [NUM_BUTTONS];
  out_item_t              merged;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEBOUNCE:   cfg_d.debounce_ms   = cfg_i.data;
        REG_LONG_PRESS: cfg_d.long_press_ms = cfg_i.data;
        default: ;
      endcase
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic       lvl;
    lane_ctrl_t ctrl;

    if (b < LevelW) begin : g_sampled
      assign lvl = in_i.item.pressed_levels[b];
    end else begin : g_unsampled
      assign lvl = 1'b0;
    end

    assign ctrl.restart = in_i.item.restart;
    assign ctrl.clear   = take_hit[b] || in_i.item.discard_all;

    bdpc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (in_fire),
      .lvl_i  (lvl),
      .now_i  (in_i.item.now_ms),
      .ctrl_i (ctrl),
      .cfg_i  (cfg_q),
      .stat_o (stat[b])
    );
  end

  bdpc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .stat_i     (stat),
    .take_i     (in_i.item.take_request),
    .idx_i      (in_i.item.button_index),
    .take_hit_o (take_hit),
    .item_o     (merged)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DEBOUNCE_RESET;
      cfg_q.long_press_ms <= LONG_PRESS_RESET;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_item_q <= merged;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted sample produced no result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty output register");

  a_no_take_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.item.take_request) |=> (out_item_q.taken_event == EV_NONE))
    else $error("event reported without a take request");

  a_restart_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.item.restart) |=>
      (out_item_q.raw_levels == out_item_q.stable_levels &&
       out_item_q.taken_event == EV_NONE && out_item_q.held_ms == '0))
    else $error("restart left raw and stable levels apart");
`endif

endmodule
